>>> src/imu_cf_pkg.sv
// Shared types, constants and helper functions of the IMU complementary filter.
// No dependencies; the controller, datapath and top level import this package.
`default_nettype none
package imu_cf_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int AtanEntries        = 24;
   localparam int IterIdxWidth       = $clog2(AtanEntries);

   localparam logic signed [33:0] PiQ24    = 34'sd52707179;
   localparam logic signed [33:0] TwoPiQ24 = 34'sd105414358;
   localparam logic [32:0]        RateK    = 33'd1144448;
   localparam logic [22:0]        MsK      = 23'd4294967;
   localparam logic [32:0]        InvGain  = 33'd39797;
   localparam logic [6:0]         StepMax  = 7'd100;
   localparam logic [6:0]         StepDflt = 7'd10;

   localparam int BiasWidth   = 20;
   localparam int WeightWidth = 16;
   localparam logic [WeightWidth-1:0] WeightReset = 16'd64225;

   typedef enum logic [0:0] {
      CSR_GYRO_Z_BIAS  = 1'b0,
      CSR_BLEND_WEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MUL_RZ, OP_MUL_RX, OP_MUL_RY, OP_MUL_DZ, OP_YAW, OP_DX, OP_DY,
      OP_CINIT_ROLL, OP_CITER, OP_CMAG, OP_CINIT_PITCH, OP_BLEND_P1, OP_BLEND_P2,
      OP_BLEND_P3, OP_BLEND_R2, OP_BLEND_R3, OP_OUT
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [IterIdxWidth-1:0] idx;
   } cmd_type;

   // Arctangent of 2^-i in Q24 radians.
   function automatic logic signed [27:0] atan_q24(input logic [IterIdxWidth-1:0] i);
      logic signed [27:0] r;
      case (i)
         5'd0:  r = 28'sd13176795;
         5'd1:  r = 28'sd7778716;
         5'd2:  r = 28'sd4110060;
         5'd3:  r = 28'sd2086331;
         5'd4:  r = 28'sd1047214;
         5'd5:  r = 28'sd524117;
         5'd6:  r = 28'sd262123;
         5'd7:  r = 28'sd131069;
         5'd8:  r = 28'sd65536;
         5'd9:  r = 28'sd32768;
         5'd10: r = 28'sd16384;
         5'd11: r = 28'sd8192;
         5'd12: r = 28'sd4096;
         5'd13: r = 28'sd2048;
         5'd14: r = 28'sd1024;
         5'd15: r = 28'sd512;
         5'd16: r = 28'sd256;
         5'd17: r = 28'sd128;
         5'd18: r = 28'sd64;
         5'd19: r = 28'sd32;
         5'd20: r = 28'sd16;
         5'd21: r = 28'sd8;
         5'd22: r = 28'sd4;
         5'd23: r = 28'sd2;
         default: r = 28'sd0;
      endcase
      return r;
   endfunction

   // Q24 value to Q4.12 output with saturation.
   function automatic logic [16:0] out17(input logic signed [33:0] v);
      logic signed [21:0] q;
      q = v[33:12];
      if (q > 22'sd65535) begin
         return 17'h0FFFF;
      end else if (q < -22'sd65536) begin
         return 17'h10000;
      end
      return q[16:0];
   endfunction

   // Saturate a blended value to 32 bit signed.
   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

>>> src/imu_cf_req_if.sv
// Input channel of the IMU complementary filter: one raw six-axis sample.
// No dependencies.
`default_nettype none
interface imu_cf_req_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic [6:0]         step_ms;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   step_ms, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 step_ms, output ready);
endinterface
`default_nettype wire

>>> src/imu_cf_rsp_if.sv
// Result channel of the IMU complementary filter: attitude in Q4.12.
// No dependencies.
`default_nettype none
interface imu_cf_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [16:0] yaw_angle;
   logic signed [16:0] yaw_rate;
   logic signed [16:0] pitch_angle;
   logic signed [16:0] roll_angle;

   modport source (output valid, yaw_angle, yaw_rate, pitch_angle, roll_angle, input ready);
   modport sink (input valid, yaw_angle, yaw_rate, pitch_angle, roll_angle, output ready);
endinterface
`default_nettype wire

>>> src/imu_cf_dpath.sv
// Datapath of the IMU complementary filter: shared multiplier, CORDIC unit and state.
// Depends on imu_cf_pkg; driven by commands from imu_cf_ctrl.
`default_nettype none
module imu_cf_dpath
   import imu_cf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   input  wire logic                   csr_we,
   input  wire logic [0:0]             csr_index,
   input  wire logic [BiasWidth-1:0]   csr_wdata,
   input  wire logic signed [15:0]     in_ax,
   input  wire logic signed [15:0]     in_ay,
   input  wire logic signed [15:0]     in_az,
   input  wire logic signed [15:0]     in_gx,
   input  wire logic signed [15:0]     in_gy,
   input  wire logic signed [15:0]     in_gz,
   input  wire logic [6:0]             in_step,
   output logic [16:0]                 yaw_angle,
   output logic [16:0]                 yaw_rate,
   output logic [16:0]                 pitch_angle,
   output logic [16:0]                 roll_angle
);

   logic [BiasWidth-1:0]   bias_ff;
   logic [WeightWidth-1:0] w_ff;
   logic [31:0] yaw_ff, yaw_in, pitch_ff, pitch_in, roll_ff, roll_in;
   logic [15:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [15:0] gx_ff, gx_in, gy_ff, gy_in, gz_ff, gz_in;
   logic [28:0] dt_ff, dt_in;
   logic [29:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic [27:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [32:0] mul_a, mul_b;
   logic [50:0] s_ff, s_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, xi, yi;
   logic signed [27:0] z_ff, z_in;
   logic zero_ff, zero_in, cinit;
   logic [27:0] rang_ff, rang_in, pang_ff, pang_in;
   logic [16:0] o_yaw_ff, o_yaw_in, o_rate_ff, o_rate_in, o_pitch_ff, o_pitch_in;
   logic [16:0] o_roll_ff, o_roll_in;
   logic [20:0] zc;
   logic [6:0]  step_c;
   logic signed [33:0] yaw_sum, shx, shy;
   logic signed [51:0] bsum;
   logic [16:0] wc;

   assign zc     = {gz_ff[15], gz_ff, 4'b0000} - {bias_ff[19], bias_ff};
   assign step_c = (in_step > StepMax) ? StepDflt : in_step;
   assign wc     = 17'd65536 - {1'b0, w_ff};
   assign yaw_sum = $signed({{2{yaw_ff[31]}}, yaw_ff}) + prod_ff[65:32];
   assign bsum   = $signed({s_ff[50], s_ff}) + prod_ff[51:0];
   assign shx    = x_ff >>> cmd.idx;
   assign shy    = y_ff >>> cmd.idx;
   assign prod_in = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff;
      gx_in = gx_ff; gy_in = gy_ff; gz_in = gz_ff;
      dt_in = dt_ff; rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff;
      dx_in = dx_ff; dy_in = dy_ff; s_in = s_ff;
      yaw_in = yaw_ff; pitch_in = pitch_ff; roll_in = roll_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; zero_in = zero_ff;
      rang_in = rang_ff; pang_in = pang_ff;
      o_yaw_in = o_yaw_ff; o_rate_in = o_rate_ff;
      o_pitch_in = o_pitch_ff; o_roll_in = o_roll_ff;
      cinit = 1'b0;
      xi = '0;
      yi = '0;
      case (cmd.op)
         OP_LOAD: begin
            ax_in = in_ax; ay_in = in_ay; az_in = in_az;
            gx_in = in_gx; gy_in = in_gy; gz_in = in_gz;
            dt_in = {22'd0, step_c} * {6'd0, MsK};
         end
         OP_MUL_RZ: begin
            mul_a = {{12{zc[20]}}, zc};
            mul_b = RateK;
         end
         OP_MUL_RX: begin
            rz_in = prod_ff[41:12];
            mul_a = {{13{gx_ff[15]}}, gx_ff, 4'b0000};
            mul_b = RateK;
         end
         OP_MUL_RY: begin
            rx_in = prod_ff[41:12];
            mul_a = {{13{gy_ff[15]}}, gy_ff, 4'b0000};
            mul_b = RateK;
         end
         OP_MUL_DZ: begin
            ry_in = prod_ff[41:12];
            mul_a = {{3{rz_ff[29]}}, rz_ff};
            mul_b = {4'b0000, dt_ff};
         end
         OP_YAW: begin
            // The step is short enough that one correction brings yaw back in range.
            if (yaw_sum > PiQ24) begin
               yaw_in = 32'(yaw_sum - TwoPiQ24);
            end else if (yaw_sum <= -PiQ24) begin
               yaw_in = 32'(yaw_sum + TwoPiQ24);
            end else begin
               yaw_in = yaw_sum[31:0];
            end
            mul_a = {{3{rx_ff[29]}}, rx_ff};
            mul_b = {4'b0000, dt_ff};
         end
         OP_DX: begin
            dx_in = prod_ff[59:32];
            mul_a = {{3{ry_ff[29]}}, ry_ff};
            mul_b = {4'b0000, dt_ff};
         end
         OP_DY: begin
            dy_in = prod_ff[59:32];
         end
         OP_CINIT_ROLL: begin
            cinit = 1'b1;
            xi = {{4{az_ff[15]}}, az_ff, 14'b0};
            yi = {{4{ay_ff[15]}}, ay_ff, 14'b0};
         end
         OP_CITER: begin
            if (!zero_ff) begin
               if (!y_ff[33]) begin
                  x_in = x_ff + shy;
                  y_in = y_ff - shx;
                  z_in = z_ff + atan_q24(cmd.idx);
               end else begin
                  x_in = x_ff - shy;
                  y_in = y_ff + shx;
                  z_in = z_ff - atan_q24(cmd.idx);
               end
            end
         end
         OP_CMAG: begin
            rang_in = z_ff;
            mul_a = x_ff[32:0];
            mul_b = InvGain;
         end
         OP_CINIT_PITCH: begin
            cinit = 1'b1;
            xi = prod_ff[49:16];
            yi = 34'sd0 - $signed({{4{ax_ff[15]}}, ax_ff, 14'b0});
         end
         OP_BLEND_P1: begin
            pang_in = z_ff;
            mul_a = $signed({pitch_ff[31], pitch_ff}) + $signed({{5{dy_ff[27]}}, dy_ff});
            mul_b = {17'b0, w_ff};
         end
         OP_BLEND_P2: begin
            s_in = prod_ff[50:0];
            mul_a = {{5{pang_ff[27]}}, pang_ff};
            mul_b = {16'b0, wc};
         end
         OP_BLEND_P3: begin
            pitch_in = sat32(bsum[51:16]);
            mul_a = $signed({roll_ff[31], roll_ff}) + $signed({{5{dx_ff[27]}}, dx_ff});
            mul_b = {17'b0, w_ff};
         end
         OP_BLEND_R2: begin
            s_in = prod_ff[50:0];
            mul_a = {{5{rang_ff[27]}}, rang_ff};
            mul_b = {16'b0, wc};
         end
         OP_BLEND_R3: begin
            roll_in = sat32(bsum[51:16]);
         end
         OP_OUT: begin
            o_yaw_in   = out17({{2{yaw_ff[31]}}, yaw_ff});
            o_rate_in  = out17({{4{rz_ff[29]}}, rz_ff});
            o_pitch_in = out17({{2{pitch_ff[31]}}, pitch_ff});
            o_roll_in  = out17({{2{roll_ff[31]}}, roll_ff});
         end
         default: begin
         end
      endcase
      if (cinit) begin
         // A zero vector gives angle and magnitude zero; iterations are frozen.
         zero_in = (xi == 34'sd0) && (yi == 34'sd0);
         if (xi < 34'sd0) begin
            x_in = -xi;
            y_in = -yi;
            z_in = (yi >= 34'sd0) ? 28'(PiQ24) : 28'(-PiQ24);
         end else begin
            x_in = xi;
            y_in = yi;
            z_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff  <= '0;
         w_ff     <= WeightReset;
         yaw_ff   <= '0;
         pitch_ff <= '0;
         roll_ff  <= '0;
      end else begin
         if (csr_we && csr_index == CSR_GYRO_Z_BIAS) begin
            bias_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_BLEND_WEIGHT) begin
            w_ff <= csr_wdata[WeightWidth-1:0];
         end
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         roll_ff  <= roll_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in;
      gx_ff <= gx_in; gy_ff <= gy_in; gz_ff <= gz_in;
      dt_ff <= dt_in; rx_ff <= rx_in; ry_ff <= ry_in; rz_ff <= rz_in;
      dx_ff <= dx_in; dy_ff <= dy_in; s_ff <= s_in; prod_ff <= prod_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; zero_ff <= zero_in;
      rang_ff <= rang_in; pang_ff <= pang_in;
      o_yaw_ff <= o_yaw_in; o_rate_ff <= o_rate_in;
      o_pitch_ff <= o_pitch_in; o_roll_ff <= o_roll_in;
   end

   assign yaw_angle   = o_yaw_ff;
   assign yaw_rate    = o_rate_ff;
   assign pitch_angle = o_pitch_ff;
   assign roll_angle  = o_roll_ff;

endmodule
`default_nettype wire

>>> src/imu_cf_ctrl.sv
// Sequencer of the IMU complementary filter: walks the datapath through one sample.
// Depends on imu_cf_pkg; drives imu_cf_dpath through cmd_type.
`default_nettype none
module imu_cf_ctrl
   import imu_cf_pkg::*;
#(
   parameter int CORDIC_STEPS = CordicStepsDefault
)
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   localparam int Iters = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
   localparam logic [IterIdxWidth-1:0] LastIter = IterIdxWidth'(Iters - 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PRE   = 6'b000010,
      S_RITER = 6'b000100,
      S_MID   = 6'b001000,
      S_PITER = 6'b010000,
      S_POST  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [IterIdxWidth-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 1'b1;
      cmd.op   = OP_NONE;
      cmd.idx  = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            case (cnt_ff)
               5'd0: cmd.op = OP_MUL_RZ;
               5'd1: cmd.op = OP_MUL_RX;
               5'd2: cmd.op = OP_MUL_RY;
               5'd3: cmd.op = OP_MUL_DZ;
               5'd4: cmd.op = OP_YAW;
               5'd5: cmd.op = OP_DX;
               5'd6: cmd.op = OP_DY;
               default: begin
                  cmd.op   = OP_CINIT_ROLL;
                  cnt_in   = '0;
                  state_in = S_RITER;
               end
            endcase
         end
         S_RITER: begin
            cmd.op = OP_CITER;
            if (cnt_ff == LastIter) begin
               cnt_in   = '0;
               state_in = S_MID;
            end
         end
         S_MID: begin
            if (cnt_ff == '0) begin
               cmd.op = OP_CMAG;
            end else begin
               cmd.op   = OP_CINIT_PITCH;
               cnt_in   = '0;
               state_in = S_PITER;
            end
         end
         S_PITER: begin
            cmd.op = OP_CITER;
            if (cnt_ff == LastIter) begin
               cnt_in   = '0;
               state_in = S_POST;
            end
         end
         S_POST: begin
            case (cnt_ff)
               5'd0: cmd.op = OP_BLEND_P1;
               5'd1: cmd.op = OP_BLEND_P2;
               5'd2: cmd.op = OP_BLEND_P3;
               5'd3: cmd.op = OP_BLEND_R2;
               5'd4: cmd.op = OP_BLEND_R3;
               default: begin
                  // Hold until the output register is free or being emptied.
                  cnt_in = cnt_ff;
                  if (slot_free) begin
                     cmd.op   = OP_OUT;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_PRE && cnt_ff == '0)
      else $error("accepted transaction did not start the sequence");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_OUT |-> slot_free)
      else $error("result written over a pending transaction");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RITER || state_ff == S_PITER) |-> cnt_ff <= LastIter)
      else $error("CORDIC iteration index out of range");

endmodule
`default_nettype wire

>>> src/imu_attitude_complementary_filter_unit.sv
// Top level of the IMU complementary filter: controller, datapath and channel ports.
// Depends on imu_cf_pkg, imu_cf_req_if, imu_cf_rsp_if, imu_cf_ctrl and imu_cf_dpath.
//
// One input transaction carries a raw six-axis sample and its time step; one result
// transaction returns wrapped yaw, the bias-corrected yaw rate, and filtered pitch and
// roll, all in Q4.12. The block handles one sample at a time: it loads the sample,
// forms the rates and angle steps, runs N CORDIC iterations for roll angle and
// magnitude, then N for pitch, and blends (N is CORDIC_STEPS, at most 24). A single
// shared multiplier forms the rate, angle step and blend products in turn; one CORDIC
// stage serves both angles. A finished result sits in an output register, so the next
// sample is taken while it waits; a sample only stalls if its own result is ready
// before the previous one has been taken. The user must write the gyro z bias and
// blend weight through the csr port only while the block is idle; it is not enforced.
`default_nettype none
module imu_attitude_complementary_filter_unit
   import imu_cf_pkg::*;
#(
   parameter int CORDIC_STEPS = CordicStepsDefault
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   imu_cf_req_if.sink                req_chan,
   imu_cf_rsp_if.source              rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [0:0]           csr_index,
   input  wire logic [BiasWidth-1:0] csr_wdata
);

   cmd_type cmd;
   logic [16:0] yaw_angle, yaw_rate, pitch_angle, roll_angle;

   // The controller sequences the datapath; the command is the only coupling.
   imu_cf_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   imu_cf_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_ax       (req_chan.accel_x),
      .in_ay       (req_chan.accel_y),
      .in_az       (req_chan.accel_z),
      .in_gx       (req_chan.gyro_x),
      .in_gy       (req_chan.gyro_y),
      .in_gz       (req_chan.gyro_z),
      .in_step     (req_chan.step_ms),
      .yaw_angle   (yaw_angle),
      .yaw_rate    (yaw_rate),
      .pitch_angle (pitch_angle),
      .roll_angle  (roll_angle)
   );

   // Result fields come straight from the datapath output register.
   assign rsp_chan.yaw_angle   = yaw_angle;
   assign rsp_chan.yaw_rate    = yaw_rate;
   assign rsp_chan.pitch_angle = pitch_angle;
   assign rsp_chan.roll_angle  = roll_angle;

endmodule
`default_nettype wire
